// ----- rtl/rti_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rti_pkg: shared types and constants of the ray/triangle intersection block
// Register indexes, hit codes, cull codes and the sideband word that rides
// along the quotient pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int COORD_BITS_DEF    = 16;
    localparam int OUT_FRAC_BITS_DEF = 16;

    // Determinant threshold register width.
    localparam int EPS_BITS      = 40;
    // Quotient bits produced by the divider: 32 result bits plus one for saturation.
    localparam int QUOT_BITS     = 33;
    localparam int CFG_ADDR_BITS = 3;
    localparam int T_BITS        = 32;
    localparam int BARY_BITS     = 17;
    // hit_t, bary_v and bary_w packed (66 bits) and padded to whole bytes.
    localparam int OUT_TDATA_W   = 72;

    localparam logic [QUOT_BITS-1:0] T_POS_MAX = 33'h0_7FFF_FFFF;
    localparam logic [QUOT_BITS-1:0] T_NEG_MAG = 33'h0_8000_0000;

    localparam logic [1:0] CULL_BOTH  = 2'd0;
    localparam logic [1:0] CULL_FRONT = 2'd1;
    localparam logic [1:0] CULL_BACK  = 2'd2;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_ORIGIN_Z  = 3'd2,
        REG_DIR_X     = 3'd3,
        REG_DIR_Y     = 3'd4,
        REG_DIR_Z     = 3'd5,
        REG_EPSILON   = 3'd6,
        REG_CULL_MODE = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        HIT_MISS  = 2'd0,
        HIT_FRONT = 2'd1,
        HIT_BACK  = 2'd2
    } hit_kind_t;

    // Control that travels with each word through the divider stages.
    typedef struct packed {
        logic      valid;
        hit_kind_t kind;
        logic      t_neg;
        logic      t_ovf;
    } div_side_t;

endpackage
`default_nettype wire

// ----- rtl/rti_div_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rti_div_stage: one restoring-division step for three quotient lanes
// Resolves quotient bit BIT of v, w and t against the shared divisor and
// registers remainders, quotients, divisor and sideband.
// ----------------------------------------------------------------------------
module rti_div_stage #(
    parameter int DW  = 54,
    parameter int RW  = 87,
    parameter int BIT = 0
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            en,
    input  wire rti_pkg::div_side_t              side_in,
    input  wire logic [DW-1:0]                   d_in,
    input  wire logic [RW-1:0]                   rv_in,
    input  wire logic [RW-1:0]                   rw_in,
    input  wire logic [RW-1:0]                   rt_in,
    input  wire logic [rti_pkg::QUOT_BITS-1:0]   qv_in,
    input  wire logic [rti_pkg::QUOT_BITS-1:0]   qw_in,
    input  wire logic [rti_pkg::QUOT_BITS-1:0]   qt_in,
    output rti_pkg::div_side_t                   side_out,
    output logic [DW-1:0]                        d_out,
    output logic [RW-1:0]                        rv_out,
    output logic [RW-1:0]                        rw_out,
    output logic [RW-1:0]                        rt_out,
    output logic [rti_pkg::QUOT_BITS-1:0]        qv_out,
    output logic [rti_pkg::QUOT_BITS-1:0]        qw_out,
    output logic [rti_pkg::QUOT_BITS-1:0]        qt_out
);

    logic [RW-1:0] dsh;
    logic          ge_v, ge_w, ge_t;
    rti_pkg::div_side_t side_reg;
    logic [DW-1:0] d_reg;
    logic [RW-1:0] rv_reg, rw_reg, rt_reg;
    logic [rti_pkg::QUOT_BITS-1:0] qv_reg, qw_reg, qt_reg;

    assign dsh  = RW'(d_in) << BIT;
    assign ge_v = rv_in >= dsh;
    assign ge_w = rw_in >= dsh;
    assign ge_t = rt_in >= dsh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= '0;
        end else if (en) begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg  <= d_in;
            rv_reg <= ge_v ? rv_in - dsh : rv_in;
            rw_reg <= ge_w ? rw_in - dsh : rw_in;
            rt_reg <= ge_t ? rt_in - dsh : rt_in;
            qv_reg <= qv_in | (rti_pkg::QUOT_BITS'(ge_v) << BIT);
            qw_reg <= qw_in | (rti_pkg::QUOT_BITS'(ge_w) << BIT);
            qt_reg <= qt_in | (rti_pkg::QUOT_BITS'(ge_t) << BIT);
        end
    end

    assign side_out = side_reg;
    assign d_out    = d_reg;
    assign rv_out   = rv_reg;
    assign rw_out   = rw_reg;
    assign rt_out   = rt_reg;
    assign qv_out   = qv_reg;
    assign qw_out   = qw_reg;
    assign qt_out   = qt_reg;

endmodule
`default_nettype wire

// ----- rtl/ray_triangle_intersect.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_intersect: pipelined Moller-Trumbore ray/triangle test
// One ray held in registers is tested against a stream of triangles.
// ----------------------------------------------------------------------------
// Usage:
// Program the ray origin, direction, determinant threshold and cull mode
// through the write port (cfg_we, cfg_addr, cfg_wdata) while no triangle is
// in flight. Then stream triangles on the s_ channel, one word per triangle
// holding nine signed vertex coordinates. Every triangle yields exactly one
// result word on the m_ channel: the hit kind on m_tuser, and t, v and w
// (already divided by the determinant) on m_tdata.
// The pipeline takes one word every cycle unless the output stalls. A word
// passes forty register stages: six arithmetic stages (edges, cross product
// terms, cross products, dot product terms, dot products, hit test), 33
// restoring-division stages, one quotient bit each, and the output register.
// The first stage loads at the accepting edge. The division chain sets the
// depth. When the receiver holds m_tready low with a result waiting, the
// whole pipeline freezes and s_tready drops; nothing is lost or repeated. A
// synchronous reset (aresetn low) empties the pipeline and loads origin 0,
// direction (0,0,256), threshold 1 and both faces enabled.
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
    parameter int COORD_BITS    = rti_pkg::COORD_BITS_DEF,
    parameter int OUT_FRAC_BITS = rti_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    // Configuration write port.
    input  wire logic                                 cfg_we,
    input  wire logic [rti_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  wire logic [((COORD_BITS > rti_pkg::EPS_BITS) ? COORD_BITS
                        : rti_pkg::EPS_BITS)-1:0]     cfg_wdata,

    // Triangle words. tdata, lowest bit up: a_x, a_y, a_z, b_x, b_y, b_z,
    // c_x, c_y, c_z, zero padding.
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [((9*COORD_BITS+7)/8)*8-1:0]    s_tdata,

    // Result words. tdata, lowest bit up: hit_t, bary_v, bary_w, zero padding.
    // tuser: hit_kind.
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [rti_pkg::OUT_TDATA_W-1:0]           m_tdata,
    output logic [1:0]                                m_tuser
);

    localparam int C   = COORD_BITS;
    localparam int EW  = C + 1;            // edge and origin offset width
    localparam int P2W = 2 * C + 2;        // cross product term width
    localparam int PQW = 2 * C + 3;        // cross product width
    localparam int P4W = PQW + EW;         // dot product term width
    localparam int DW  = 3 * C + 6;        // dot product width
    localparam int QB  = rti_pkg::QUOT_BITS;
    localparam int RW  = DW + QB;          // dividend and remainder width
    localparam int CW  = ((DW > rti_pkg::EPS_BITS) ? DW : rti_pkg::EPS_BITS) + 2;

    // Ray registers.
    logic signed [C-1:0]              org_reg [3];
    logic signed [C-1:0]              dir_reg [3];
    logic [rti_pkg::EPS_BITS-1:0]     eps_reg;
    logic [1:0]                       cull_reg;

    // Global advance: the pipeline moves whenever the output slot is free or taken.
    logic m_tvalid_reg;
    logic en;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                org_reg[k] <= '0;
                dir_reg[k] <= '0;
            end
            dir_reg[2] <= C'(256);
            eps_reg    <= rti_pkg::EPS_BITS'(1);
            cull_reg   <= rti_pkg::CULL_BOTH;
        end else if (cfg_we) begin
            unique case (rti_pkg::cfg_reg_t'(cfg_addr))
                rti_pkg::REG_ORIGIN_X:  org_reg[0] <= cfg_wdata[C-1:0];
                rti_pkg::REG_ORIGIN_Y:  org_reg[1] <= cfg_wdata[C-1:0];
                rti_pkg::REG_ORIGIN_Z:  org_reg[2] <= cfg_wdata[C-1:0];
                rti_pkg::REG_DIR_X:     dir_reg[0] <= cfg_wdata[C-1:0];
                rti_pkg::REG_DIR_Y:     dir_reg[1] <= cfg_wdata[C-1:0];
                rti_pkg::REG_DIR_Z:     dir_reg[2] <= cfg_wdata[C-1:0];
                rti_pkg::REG_EPSILON:   eps_reg    <= cfg_wdata[rti_pkg::EPS_BITS-1:0];
                rti_pkg::REG_CULL_MODE: cull_reg   <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Stage valid bits for the arithmetic stages.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Stage 1: edges e1 = b - a, e2 = c - a and origin offset s = origin - a.
    logic signed [C-1:0]  vtx [9];
    logic signed [EW-1:0] e1_s1_reg [3], e2_s1_reg [3], s_s1_reg [3];

    for (genvar i = 0; i < 9; i++) begin : g_unpack
        assign vtx[i] = s_tdata[i*C +: C];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                e1_s1_reg[k] <= EW'(vtx[3+k]) - EW'(vtx[k]);
                e2_s1_reg[k] <= EW'(vtx[6+k]) - EW'(vtx[k]);
                s_s1_reg[k]  <= EW'(org_reg[k]) - EW'(vtx[k]);
            end
        end
    end

    // Stage 2: the two products of each cross product component,
    // p = dir x e2 and q = s x e1.
    logic signed [P2W-1:0] pa_s2_reg [3], pb_s2_reg [3], qa_s2_reg [3], qb_s2_reg [3];
    logic signed [EW-1:0]  e1_s2_reg [3], e2_s2_reg [3], s_s2_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                pa_s2_reg[k] <= P2W'(dir_reg[(k+1)%3] * e2_s1_reg[(k+2)%3]);
                pb_s2_reg[k] <= P2W'(dir_reg[(k+2)%3] * e2_s1_reg[(k+1)%3]);
                qa_s2_reg[k] <= P2W'(s_s1_reg[(k+1)%3] * e1_s1_reg[(k+2)%3]);
                qb_s2_reg[k] <= P2W'(s_s1_reg[(k+2)%3] * e1_s1_reg[(k+1)%3]);
                e1_s2_reg[k] <= e1_s1_reg[k];
                e2_s2_reg[k] <= e2_s1_reg[k];
                s_s2_reg[k]  <= s_s1_reg[k];
            end
        end
    end

    // Stage 3: cross products.
    logic signed [PQW-1:0] p_s3_reg [3], q_s3_reg [3];
    logic signed [EW-1:0]  e1_s3_reg [3], e2_s3_reg [3], s_s3_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                p_s3_reg[k]  <= PQW'(pa_s2_reg[k]) - PQW'(pb_s2_reg[k]);
                q_s3_reg[k]  <= PQW'(qa_s2_reg[k]) - PQW'(qb_s2_reg[k]);
                e1_s3_reg[k] <= e1_s2_reg[k];
                e2_s3_reg[k] <= e2_s2_reg[k];
                s_s3_reg[k]  <= s_s2_reg[k];
            end
        end
    end

    // Stage 4: dot product terms for det = p.e1, v = p.s, w = q.dir, t = q.e2.
    logic signed [P4W-1:0] dm_s4_reg [3], vm_s4_reg [3], wm_s4_reg [3], tm_s4_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                dm_s4_reg[k] <= P4W'(p_s3_reg[k] * e1_s3_reg[k]);
                vm_s4_reg[k] <= P4W'(p_s3_reg[k] * s_s3_reg[k]);
                wm_s4_reg[k] <= P4W'(q_s3_reg[k] * dir_reg[k]);
                tm_s4_reg[k] <= P4W'(q_s3_reg[k] * e2_s3_reg[k]);
            end
        end
    end

    // Stage 5: dot products.
    logic signed [DW-1:0] det_s5_reg, v_s5_reg, w_s5_reg, t_s5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            det_s5_reg <= DW'(dm_s4_reg[0]) + DW'(dm_s4_reg[1]) + DW'(dm_s4_reg[2]);
            v_s5_reg   <= DW'(vm_s4_reg[0]) + DW'(vm_s4_reg[1]) + DW'(vm_s4_reg[2]);
            w_s5_reg   <= DW'(wm_s4_reg[0]) + DW'(wm_s4_reg[1]) + DW'(wm_s4_reg[2]);
            t_s5_reg   <= DW'(tm_s4_reg[0]) + DW'(tm_s4_reg[1]) + DW'(tm_s4_reg[2]);
        end
    end

    // Stage 6: face and barycentric test, magnitudes and the dividends.
    logic signed [CW-1:0]   det_c, eps_c;
    logic signed [DW:0]     vw_sum, det_x;
    logic                   front_ok, back_ok, t_ovf;
    rti_pkg::hit_kind_t     kind;
    logic [DW-1:0]          det_abs, v_abs, w_abs, t_abs;
    logic [RW-1:0]          nt;

    always_comb begin
        det_c  = CW'(det_s5_reg);
        eps_c  = CW'($signed({1'b0, eps_reg}));
        vw_sum = (DW+1)'(v_s5_reg) + (DW+1)'(w_s5_reg);
        det_x  = (DW+1)'(det_s5_reg);

        // Back faces need v and w at or below zero, so test the sign bit or zero.
        front_ok = (det_c > eps_c) && !v_s5_reg[DW-1] && (v_s5_reg <= det_s5_reg)
                   && !w_s5_reg[DW-1] && (vw_sum <= det_x)
                   && (cull_reg != rti_pkg::CULL_BACK);
        back_ok  = (det_c < -eps_c) && (v_s5_reg[DW-1] || (v_s5_reg == '0))
                   && (v_s5_reg >= det_s5_reg)
                   && (w_s5_reg[DW-1] || (w_s5_reg == '0)) && (vw_sum >= det_x)
                   && (cull_reg != rti_pkg::CULL_FRONT);

        priority if (front_ok) begin
            kind = rti_pkg::HIT_FRONT;
        end else if (back_ok) begin
            kind = rti_pkg::HIT_BACK;
        end else begin
            kind = rti_pkg::HIT_MISS;
        end

        det_abs = det_s5_reg[DW-1] ? DW'(-det_s5_reg) : DW'(det_s5_reg);
        v_abs   = v_s5_reg[DW-1]   ? DW'(-v_s5_reg)   : DW'(v_s5_reg);
        w_abs   = w_s5_reg[DW-1]   ? DW'(-w_s5_reg)   : DW'(w_s5_reg);
        t_abs   = t_s5_reg[DW-1]   ? DW'(-t_s5_reg)   : DW'(t_s5_reg);

        // A t quotient of 2^33 or more saturates either way.
        nt    = RW'(t_abs) << OUT_FRAC_BITS;
        t_ovf = {1'b0, nt} >= ((RW+1)'(det_abs) << QB);
    end

    rti_pkg::div_side_t side_pipe [QB+1];
    logic [DW-1:0]      d_pipe    [QB+1];
    logic [RW-1:0]      rv_pipe   [QB+1];
    logic [RW-1:0]      rw_pipe   [QB+1];
    logic [RW-1:0]      rt_pipe   [QB+1];
    logic [QB-1:0]      qv_pipe   [QB+1];
    logic [QB-1:0]      qw_pipe   [QB+1];
    logic [QB-1:0]      qt_pipe   [QB+1];
    rti_pkg::div_side_t side_s6_reg;
    logic [DW-1:0]      d_s6_reg;
    logic [RW-1:0]      rv_s6_reg, rw_s6_reg, rt_s6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_s6_reg <= '0;
        end else if (en) begin
            side_s6_reg.valid <= v5_reg;
            side_s6_reg.kind  <= kind;
            side_s6_reg.t_neg <= t_s5_reg[DW-1] ^ det_s5_reg[DW-1];
            side_s6_reg.t_ovf <= t_ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_s6_reg  <= det_abs;
            rv_s6_reg <= RW'(v_abs) << OUT_FRAC_BITS;
            rw_s6_reg <= RW'(w_abs) << OUT_FRAC_BITS;
            rt_s6_reg <= nt;
        end
    end

    assign side_pipe[0] = side_s6_reg;
    assign d_pipe[0]    = d_s6_reg;
    assign rv_pipe[0]   = rv_s6_reg;
    assign rw_pipe[0]   = rw_s6_reg;
    assign rt_pipe[0]   = rt_s6_reg;
    assign qv_pipe[0]   = '0;
    assign qw_pipe[0]   = '0;
    assign qt_pipe[0]   = '0;

    // Division chain: stage j settles quotient bit QB-1-j of all three lanes.
    for (genvar j = 0; j < QB; j++) begin : g_div
        rti_div_stage #(
            .DW  (DW),
            .RW  (RW),
            .BIT (QB - 1 - j)
        ) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .side_in  (side_pipe[j]),
            .d_in     (d_pipe[j]),
            .rv_in    (rv_pipe[j]),
            .rw_in    (rw_pipe[j]),
            .rt_in    (rt_pipe[j]),
            .qv_in    (qv_pipe[j]),
            .qw_in    (qw_pipe[j]),
            .qt_in    (qt_pipe[j]),
            .side_out (side_pipe[j+1]),
            .d_out    (d_pipe[j+1]),
            .rv_out   (rv_pipe[j+1]),
            .rw_out   (rw_pipe[j+1]),
            .rt_out   (rt_pipe[j+1]),
            .qv_out   (qv_pipe[j+1]),
            .qw_out   (qw_pipe[j+1]),
            .qt_out   (qt_pipe[j+1])
        );
    end

    // Output stage: saturate t, apply its sign, clear everything on a miss.
    rti_pkg::div_side_t   side_last;
    logic [QB-1:0]        t_mag;
    logic [rti_pkg::T_BITS-1:0]    t_val;
    logic [rti_pkg::BARY_BITS-1:0] bv_val, bw_val;
    logic                 is_hit;

    assign side_last = side_pipe[QB];

    always_comb begin
        if (!side_last.t_neg) begin
            t_mag = (side_last.t_ovf || qt_pipe[QB] > rti_pkg::T_POS_MAX)
                    ? rti_pkg::T_POS_MAX : qt_pipe[QB];
            t_val = t_mag[rti_pkg::T_BITS-1:0];
        end else begin
            t_mag = (side_last.t_ovf || qt_pipe[QB] > rti_pkg::T_NEG_MAG)
                    ? rti_pkg::T_NEG_MAG : qt_pipe[QB];
            t_val = -t_mag[rti_pkg::T_BITS-1:0];
        end
        is_hit = side_last.kind != rti_pkg::HIT_MISS;
        bv_val = qv_pipe[QB][rti_pkg::BARY_BITS-1:0];
        bw_val = qw_pipe[QB][rti_pkg::BARY_BITS-1:0];
    end

    logic [1:0]                     m_kind_reg;
    logic [rti_pkg::T_BITS-1:0]     m_t_reg;
    logic [rti_pkg::BARY_BITS-1:0]  m_v_reg, m_w_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= side_last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_kind_reg <= side_last.kind;
            m_t_reg    <= is_hit ? t_val  : '0;
            m_v_reg    <= is_hit ? bv_val : '0;
            m_w_reg    <= is_hit ? bw_val : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = rti_pkg::OUT_TDATA_W'({m_w_reg, m_v_reg, m_t_reg});

    // A freshly reset pipeline shows no result.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

    // A waiting result freezes the whole pipeline, input side included.
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while the output is stalled");

    // A miss carries all-zero numeric fields.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rti_pkg::HIT_MISS |-> m_tdata == '0)
        else $error("miss with nonzero payload");

    // The hit test keeps |v| within |det|, so its quotient never exceeds one.
    a_bary_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        side_last.valid && side_last.kind != rti_pkg::HIT_MISS
        |-> qv_pipe[QB] <= (QB'(1) << OUT_FRAC_BITS))
        else $error("barycentric quotient above one on a hit");

endmodule
`default_nettype wire
